// File: rtl/pid3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid3_pkg: shared types and constants
// Field widths, fixed-point constants, register indexes and saturation helper
// for the three-axis PID velocity controller.
// ----------------------------------------------------------------------------
package pid3_pkg;

  localparam int FIELD_W    = 24;
  localparam int VALUE_W    = 24;
  localparam int GAIN_W     = 16;
  localparam int HEAD_IN_W  = 17;
  localparam int HEAD_EXT_W = HEAD_IN_W + 1;
  localparam int HEAD_W     = 16;
  localparam int INT_W      = 32;
  localparam int DER_W      = FIELD_W + 1;
  localparam int NUM_AXES   = 3;

  localparam int PP_W  = GAIN_W + FIELD_W;
  localparam int PI_W  = GAIN_W + INT_W;
  localparam int PD_W  = GAIN_W + DER_W;
  localparam int PH_W  = GAIN_W + HEAD_W;
  localparam int SUM_W = PI_W + 2;
  localparam int SH_W  = SUM_W - 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic signed [HEAD_EXT_W-1:0] Q_PI     = HEAD_EXT_W'(12868);
  localparam logic signed [HEAD_EXT_W-1:0] Q_TWO_PI = HEAD_EXT_W'(25736);

  localparam logic signed [GAIN_W-1:0]  RST_GAIN_P  = GAIN_W'(256);
  localparam logic signed [GAIN_W-1:0]  RST_GAIN_I  = GAIN_W'(256);
  localparam logic signed [GAIN_W-1:0]  RST_GAIN_D  = GAIN_W'(256);
  localparam logic signed [GAIN_W-1:0]  RST_GAIN_H  = GAIN_W'(0);
  localparam logic signed [FIELD_W-1:0] RST_ALT_THR = FIELD_W'(410);

  localparam logic signed [SH_W-1:0] VMAX = SH_W'((64'sd1 <<< (VALUE_W - 1)) - 64'sd1);
  localparam logic signed [SH_W-1:0] VMIN = -VMAX - SH_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_GAIN_H   = 3'd3,
    REG_ALT_THR  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  p;
    logic signed [GAIN_W-1:0]  i;
    logic signed [GAIN_W-1:0]  d;
    logic signed [GAIN_W-1:0]  h;
    logic signed [FIELD_W-1:0] alt_thr;
  } gains_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] err;
    logic signed [INT_W-1:0]   integ;
    logic signed [DER_W-1:0]   deriv;
  } axis_op_t;

  typedef struct packed {
    logic s2_load;
    logic out_load;
  } pipe_en_t;

  // saturate to the value range, then keep the field bits
  function automatic logic [FIELD_W-1:0] sat_field(input logic signed [SH_W-1:0] v);
    logic signed [SH_W-1:0] lim;
    lim = v;
    if (v > VMAX) begin
      lim = VMAX;
    end else if (v < VMIN) begin
      lim = VMIN;
    end
    return lim[FIELD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/pid3_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid3_in_if: input item channel
// Target offset, altitude and heading error with valid/ready.
// ----------------------------------------------------------------------------
interface pid3_in_if import pid3_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_W-1:0]    target_x_body;
  logic signed [FIELD_W-1:0]    target_y_body;
  logic signed [FIELD_W-1:0]    target_z_body;
  logic signed [FIELD_W-1:0]    altitude;
  logic signed [HEAD_IN_W-1:0]  heading_error;

  modport source (output valid, target_x_body, target_y_body, target_z_body,
                  altitude, heading_error, input ready);
  modport sink   (input valid, target_x_body, target_y_body, target_z_body,
                  altitude, heading_error, output ready);
endinterface
`default_nettype wire

// File: rtl/pid3_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid3_out_if: result item channel
// Commanded velocities and yaw rate with valid/ready.
// ----------------------------------------------------------------------------
interface pid3_out_if import pid3_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] vel_x;
  logic signed [FIELD_W-1:0] vel_y;
  logic signed [FIELD_W-1:0] vel_z;
  logic signed [FIELD_W-1:0] yaw_rate;

  modport source (output valid, vel_x, vel_y, vel_z, yaw_rate, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, yaw_rate, output ready);
endinterface
`default_nettype wire

// File: rtl/pid3_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid3_cfg_if: configuration write channel
// Register index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface pid3_cfg_if import pid3_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/three_axis_pid_velocity_controller_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_axis_pid_velocity_controller_unit: three-axis PID with yaw rate
// Usage:
//   in_ch  : one control tick per item (target offset, altitude, heading).
//   out_ch : one result item per input item (vel_x/y/z, yaw_rate).
//   cfg_ch : register writes (gains, altitude threshold); always ready.
//            Write only while no item is in flight.
// Path: an accepted item passes the operand register, the product register
//   and the output register; a stall on out_ch can hold it in any of them.
// Throughput: one item per cycle while out_ch is ready; each stage has its
//   own valid bit, so a new item is taken while a result waits on out_ch.
// Stall: the output register holds its item until taken; the stages behind
//   it fill, and in_ch.ready drops only once all three stages are full.
// Reset: gains return to defaults, integrals and previous errors clear,
//   and all pipeline valid bits clear.
// ----------------------------------------------------------------------------
module three_axis_pid_velocity_controller_unit import pid3_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pid3_in_if.sink    in_ch,
  pid3_out_if.source out_ch,
  pid3_cfg_if.sink   cfg_ch
);

  gains_t                   gains;
  axis_op_t                 ops [NUM_AXES];
  logic signed [HEAD_W-1:0] head;
  logic [FIELD_W-1:0]       vel [NUM_AXES];
  logic [FIELD_W-1:0]       yaw;
  pipe_en_t                 en;

  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  logic out_v_r, out_v_nxt;
  logic out_en, s2_rdy, s1_rdy, accept;

  assign out_en      = !out_v_r || out_ch.ready;
  assign s2_rdy      = !s2_v_r || out_en;
  assign s1_rdy      = !s1_v_r || s2_rdy;
  assign in_ch.ready = s1_rdy;
  assign accept      = in_ch.valid && s1_rdy;

  assign en.s2_load  = s1_v_r && s2_rdy;
  assign en.out_load = s2_v_r && out_en;

  always_comb begin
    s1_v_nxt  = accept ? 1'b1 : (s2_rdy ? 1'b0 : s1_v_r);
    s2_v_nxt  = en.s2_load ? 1'b1 : (out_en ? 1'b0 : s2_v_r);
    out_v_nxt = en.out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  pid3_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .gains  (gains)
  );

  pid3_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .target_x_body (in_ch.target_x_body),
    .target_y_body (in_ch.target_y_body),
    .target_z_body (in_ch.target_z_body),
    .altitude      (in_ch.altitude),
    .heading_error (in_ch.heading_error),
    .gains         (gains),
    .ops           (ops),
    .head          (head)
  );

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
    pid3_axis u_axis (
      .clk   (clk),
      .en    (en),
      .gains (gains),
      .op    (ops[k]),
      .vel   (vel[k])
    );
  end

  pid3_yaw u_yaw (
    .clk      (clk),
    .en       (en),
    .gains    (gains),
    .head     (head),
    .yaw_rate (yaw)
  );

  assign out_ch.valid    = out_v_r;
  assign out_ch.vel_x    = vel[0];
  assign out_ch.vel_y    = vel[1];
  assign out_ch.vel_z    = vel[2];
  assign out_ch.yaw_rate = yaw;

endmodule
`default_nettype wire

// File: rtl/pid3_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid3_cfg: configuration registers
// Gains and altitude threshold, written through the configuration channel.
// ----------------------------------------------------------------------------
module pid3_cfg import pid3_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pid3_cfg_if.sink   cfg_ch,
  output gains_t     gains
);

  gains_t gains_r, gains_nxt;
  logic   wr;

  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid && cfg_ch.ready;

  always_comb begin
    gains_nxt = gains_r;
    if (wr) begin
      unique case (cfg_ch.index)
        REG_GAIN_P:  gains_nxt.p       = cfg_ch.data[GAIN_W-1:0];
        REG_GAIN_I:  gains_nxt.i       = cfg_ch.data[GAIN_W-1:0];
        REG_GAIN_D:  gains_nxt.d       = cfg_ch.data[GAIN_W-1:0];
        REG_GAIN_H:  gains_nxt.h       = cfg_ch.data[GAIN_W-1:0];
        REG_ALT_THR: gains_nxt.alt_thr = cfg_ch.data[FIELD_W-1:0];
        default:     gains_nxt = gains_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.p       <= RST_GAIN_P;
      gains_r.i       <= RST_GAIN_I;
      gains_r.d       <= RST_GAIN_D;
      gains_r.h       <= RST_GAIN_H;
      gains_r.alt_thr <= RST_ALT_THR;
    end else begin
      gains_r <= gains_nxt;
    end
  end

  assign gains = gains_r;

endmodule
`default_nettype wire

// File: rtl/pid3_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid3_front: error, integral and derivative stage
// Holds integral and previous error per axis, updates them on each accepted
// item (integral only if airborne); registers ops and wrapped heading error.
// ----------------------------------------------------------------------------
module pid3_front import pid3_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic signed [FIELD_W-1:0]     target_x_body,
  input  wire logic signed [FIELD_W-1:0]     target_y_body,
  input  wire logic signed [FIELD_W-1:0]     target_z_body,
  input  wire logic signed [FIELD_W-1:0]     altitude,
  input  wire logic signed [HEAD_IN_W-1:0]   heading_error,
  input  gains_t                             gains,
  output axis_op_t                           ops [NUM_AXES],
  output logic signed [HEAD_W-1:0]           head
);

  logic signed [INT_W-1:0]   integ_r [NUM_AXES];
  logic signed [INT_W-1:0]   integ_nxt [NUM_AXES];
  logic signed [FIELD_W-1:0] prev_r [NUM_AXES];
  logic signed [FIELD_W-1:0] err [NUM_AXES];
  axis_op_t                  ops_r [NUM_AXES];
  axis_op_t                  ops_nxt [NUM_AXES];
  logic signed [HEAD_W-1:0]  head_r, head_nxt;
  logic                      airborne;

  function automatic logic signed [HEAD_W-1:0] wrap_head(
    input logic signed [HEAD_IN_W-1:0] h_in);
    logic signed [HEAD_EXT_W-1:0] h;
    logic signed [HEAD_EXT_W-1:0] r;
    h = HEAD_EXT_W'(h_in);
    r = h;
    if (h > Q_PI) begin
      if (h - Q_TWO_PI <= Q_PI) begin
        r = h - Q_TWO_PI;
      end else if (h - (Q_TWO_PI <<< 1) <= Q_PI) begin
        r = h - (Q_TWO_PI <<< 1);
      end else begin
        r = h - (Q_TWO_PI <<< 1) - Q_TWO_PI;
      end
    end else if (h < -Q_PI) begin
      if (h + Q_TWO_PI >= -Q_PI) begin
        r = h + Q_TWO_PI;
      end else if (h + (Q_TWO_PI <<< 1) >= -Q_PI) begin
        r = h + (Q_TWO_PI <<< 1);
      end else begin
        r = h + (Q_TWO_PI <<< 1) + Q_TWO_PI;
      end
    end
    return r[HEAD_W-1:0];
  endfunction

  assign err[0]   = target_y_body;
  assign err[1]   = target_x_body;
  assign err[2]   = target_z_body;
  assign airborne = altitude > gains.alt_thr;
  assign head_nxt = wrap_head(heading_error);

  always_comb begin
    logic signed [INT_W:0] s;
    for (int k = 0; k < NUM_AXES; k++) begin
      s = (INT_W+1)'(integ_r[k]) + (INT_W+1)'(err[k]);
      if (s[INT_W] != s[INT_W-1]) begin
        integ_nxt[k] = s[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
      end else begin
        integ_nxt[k] = s[INT_W-1:0];
      end
      if (!airborne) begin
        integ_nxt[k] = integ_r[k];
      end
      ops_nxt[k].err   = err[k];
      ops_nxt[k].integ = integ_nxt[k];
      ops_nxt[k].deriv = DER_W'(err[k]) - DER_W'(prev_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        integ_r[k] <= '0;
        prev_r[k]  <= '0;
      end
    end else if (accept) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        integ_r[k] <= integ_nxt[k];
        prev_r[k]  <= err[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ops_r  <= ops_nxt;
      head_r <= head_nxt;
    end
  end

  assign ops  = ops_r;
  assign head = head_r;

endmodule
`default_nettype wire

// File: rtl/pid3_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid3_axis: per-axis multiply-add
// Registers the three gain products, then sums, floors by 2^8 and saturates.
// ----------------------------------------------------------------------------
module pid3_axis import pid3_pkg::*; (
  input  wire logic               clk,
  input  pipe_en_t                en,
  input  gains_t                  gains,
  input  axis_op_t                op,
  output logic [FIELD_W-1:0]      vel
);

  logic signed [PP_W-1:0]  pp_r;
  logic signed [PI_W-1:0]  pi_r;
  logic signed [PD_W-1:0]  pd_r;
  logic signed [SUM_W-1:0] sum;
  logic signed [SH_W-1:0]  sh;
  logic [FIELD_W-1:0]      vel_r;

  always_ff @(posedge clk) begin
    if (en.s2_load) begin
      pp_r <= gains.p * op.err;
      pi_r <= gains.i * op.integ;
      pd_r <= gains.d * op.deriv;
    end
  end

  assign sum = SUM_W'(pp_r) + SUM_W'(pi_r) + SUM_W'(pd_r);
  assign sh  = SH_W'(sum >>> 8);

  always_ff @(posedge clk) begin
    if (en.out_load) begin
      vel_r <= sat_field(sh);
    end
  end

  assign vel = vel_r;

endmodule
`default_nettype wire

// File: rtl/pid3_yaw.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid3_yaw: yaw rate from wrapped heading error
// Registered heading gain product, floored by 2^8 and saturated.
// ----------------------------------------------------------------------------
module pid3_yaw import pid3_pkg::*; (
  input  wire logic               clk,
  input  pipe_en_t                en,
  input  gains_t                  gains,
  input  wire logic signed [HEAD_W-1:0] head,
  output logic [FIELD_W-1:0]      yaw_rate
);

  logic signed [PH_W-1:0] ph_r;
  logic signed [SH_W-1:0] sh;
  logic [FIELD_W-1:0]     yaw_r;

  always_ff @(posedge clk) begin
    if (en.s2_load) begin
      ph_r <= gains.h * head;
    end
  end

  assign sh = SH_W'(ph_r) >>> 8;

  always_ff @(posedge clk) begin
    if (en.out_load) begin
      yaw_r <= sat_field(sh);
    end
  end

  assign yaw_rate = yaw_r;

endmodule
`default_nettype wire

// File: rtl/pid3_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid3_chk: port-level checks
// Output hold under stall, reset behavior and input readiness.
// ----------------------------------------------------------------------------
module pid3_chk import pid3_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [FIELD_W-1:0] vel_x,
  input wire logic [FIELD_W-1:0] vel_y,
  input wire logic [FIELD_W-1:0] vel_z,
  input wire logic [FIELD_W-1:0] yaw_rate
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(vel_x) && $stable(vel_y) &&
                                $stable(vel_z) && $stable(yaw_rate))
    else $error("result payload changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input not ready while output drains");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rst_n, 3) && !$past(!rst_n, 1))
    else $error("result appeared too soon after reset");

endmodule

bind three_axis_pid_velocity_controller_unit pid3_chk u_pid3_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .vel_x     (out_ch.vel_x),
  .vel_y     (out_ch.vel_y),
  .vel_z     (out_ch.vel_z),
  .yaw_rate  (out_ch.yaw_rate)
);
`default_nettype wire
